// File: rtl/ldrs_pkg.sv
// shared types and constants of the linear diophantine range solver
package ldrs_pkg;

  // field widths and internal datapath widths
  localparam int FIELD_BITS = 32;
  localparam int GCD_BITS   = 31;
  localparam int WIDE_BITS  = 66;   // k bounds, products, wide dividends
  localparam int DEN_BITS   = 34;   // signed divisor
  localparam int REM_BITS   = 33;   // signed remainder
  localparam int MUL_BITS   = 33;   // signed multiplier operand

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NODIV = 2'd1,
    ST_NONE  = 2'd2,
    ST_ZERO  = 2'd3
  } ldrs_status_t;

  // datapath operations, the solve sequence in program order first
  typedef enum logic [5:0] {
    OP_DIV_EUC, OP_SET_EQ, OP_MUL_QU, OP_SET_EU,
    OP_SET_G, OP_DIV_S, OP_SET_S, OP_DIV_CG, OP_SET_CG,
    OP_DIV_U0S, OP_SET_M1, OP_DIV_CGS, OP_SET_M2, OP_MUL_M,
    OP_DIV_PS, OP_SET_X0, OP_MUL_AX, OP_DIV_Y, OP_SET_Y0,
    OP_DIV_T, OP_SET_T, OP_DIV_KL, OP_SET_KL, OP_DIV_KH, OP_SET_KH,
    OP_DIV_LO, OP_SET_LO, OP_DIV_HI, OP_SET_HI, OP_CHK,
    OP_MUL_KLS, OP_SET_FX, OP_MUL_KLT, OP_SET_FY,
    OP_MUL_KHS, OP_SET_LX, OP_MUL_KHT, OP_SET_LY,
    OP_NOP, OP_LOAD, OP_OUT
  } ldrs_op_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] coef_a;
    logic signed [FIELD_BITS-1:0] coef_b;
    logic signed [FIELD_BITS-1:0] rhs_c;
    logic signed [FIELD_BITS-1:0] x_low;
    logic signed [FIELD_BITS-1:0] x_high;
    logic signed [FIELD_BITS-1:0] y_low;
    logic signed [FIELD_BITS-1:0] y_high;
  } ldrs_in_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [GCD_BITS-1:0]          gcd_value;
    logic signed [FIELD_BITS-1:0] first_x;
    logic signed [FIELD_BITS-1:0] first_y;
    logic signed [FIELD_BITS-1:0] last_x;
    logic signed [FIELD_BITS-1:0] last_y;
    logic [GCD_BITS-1:0]          x_step;
    logic [FIELD_BITS-1:0]        solution_count;
  } ldrs_out_t;

  // controller to datapath
  typedef struct packed {
    ldrs_op_t     op;
    logic         div_start;
    ldrs_status_t stat;
  } ldrs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic r1_zero;
    logic zero_coef;
    logic rem_nz;
    logic k_empty;
  } ldrs_sts_t;

endpackage

// File: rtl/ldrs_if.sv
// valid/ready channel interfaces for input and result transactions
interface ldrs_in_if;
  import ldrs_pkg::*;
  logic     valid;
  logic     ready;
  ldrs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ldrs_out_if;
  import ldrs_pkg::*;
  logic      valid;
  logic      ready;
  ldrs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ldrs_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
module ldrs_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ldrs_pkg::WIDE_BITS-1:0] num,
  input  logic signed [ldrs_pkg::DEN_BITS-1:0]  den,
  output logic                                 done,
  output logic signed [ldrs_pkg::WIDE_BITS-1:0] quo,
  output logic signed [ldrs_pkg::REM_BITS-1:0]  rem
);
  import ldrs_pkg::*;

  localparam int MAG_BITS = 64;
  localparam int DM_BITS  = 32;
  localparam logic [6:0] LONG_CNT  = 7'd64;
  localparam logic [6:0] SHORT_CNT = 7'd32;

  logic                         busy_r;
  logic                         done_r;
  logic [6:0]                   cnt_r;
  logic [MAG_BITS-1:0]          quo_r;
  logic [DM_BITS-1:0]           rem_r;
  logic [DM_BITS-1:0]           dmag_r;
  logic                         negq_r;
  logic                         negr_r;
  logic signed [WIDE_BITS-1:0]  nabs;
  logic signed [DEN_BITS-1:0]   dabs;
  logic [MAG_BITS-1:0]          nmag;
  logic                         short_op;
  logic [DM_BITS:0]             shv;
  logic [DM_BITS:0]             diff;
  logic                         ge;

  // operand magnitudes
  always_comb begin
    nabs     = num[WIDE_BITS-1] ? -num : num;
    dabs     = den[DEN_BITS-1] ? -den : den;
    nmag     = nabs[MAG_BITS-1:0];
    short_op = (nmag[MAG_BITS-1:DM_BITS] == '0);
  end

  // restoring step
  always_comb begin
    shv  = {rem_r, quo_r[MAG_BITS-1]};
    diff = shv - {1'b0, dmag_r};
    ge   = (shv >= {1'b0, dmag_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= short_op ? SHORT_CNT : LONG_CNT;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= short_op ? {nmag[DM_BITS-1:0], {DM_BITS{1'b0}}} : nmag;
      rem_r  <= '0;
      dmag_r <= dabs[DM_BITS-1:0];
      negq_r <= num[WIDE_BITS-1] ^ den[DEN_BITS-1];
      negr_r <= num[WIDE_BITS-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[MAG_BITS-2:0], ge};
      rem_r <= ge ? diff[DM_BITS-1:0] : shv[DM_BITS-1:0];
    end
  end

  assign done = done_r;
  assign quo  = negq_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign rem  = negr_r ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 7'd0) else $error("divider busy with empty count");

endmodule

// File: rtl/ldrs_dp.sv
// solver datapath: operand registers, shared multiplier, divider, result register
module ldrs_dp #(
  parameter int OP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ldrs_pkg::ldrs_cmd_t cmd,
  output ldrs_pkg::ldrs_sts_t sts,
  input  ldrs_pkg::ldrs_in_t  in_data,
  output ldrs_pkg::ldrs_out_t out_data
);
  import ldrs_pkg::*;

  localparam int FB = FIELD_BITS;

  logic signed [FB-1:0]        a_r, b_r, c_r, xl_r, xh_r, yl_r, yh_r;
  logic [FB-1:0]               r0_r, r1_r, q_r, g_r, s_r, m1_r, m2_r, x0_r;
  logic [FB-1:0]               fx_r, fy_r, lx_r, ly_r;
  logic signed [MUL_BITS-1:0]  u0_r, u1_r, t_r;
  logic signed [FB-1:0]        cg_r;
  logic signed [63:0]          y0_r;
  logic signed [WIDE_BITS-1:0] kl_r, kh_r, prod_r;
  ldrs_out_t                   out_r;

  logic signed [WIDE_BITS-1:0] div_num;
  logic signed [DEN_BITS-1:0]  div_den;
  logic                        div_done;
  logic signed [WIDE_BITS-1:0] div_quo;
  logic signed [REM_BITS-1:0]  div_rem;
  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [WIDE_BITS-1:0] mul_p;
  logic signed [WIDE_BITS-1:0] k_ceil, k_floor, cnt_w;
  logic signed [REM_BITS-1:0]  rem_pos;
  logic signed [MUL_BITS-1:0]  t_abs;
  logic                        t_pos;
  logic signed [FB-1:0]        sa, sb;

  // sign extension from the operand width
  function automatic logic signed [FB-1:0] sext(input logic [FB-1:0] v);
    logic [FB-1:0] sh;
    sh   = v << (FB - OP_BITS);
    sext = $signed(sh) >>> (FB - OP_BITS);
  endfunction

  function automatic logic [FB-1:0] abs32(input logic signed [FB-1:0] v);
    abs32 = v[FB-1] ? -v : v;
  endfunction

  function automatic logic [GCD_BITS-1:0] sat31(input logic [FB-1:0] v);
    sat31 = v[FB-1] ? {GCD_BITS{1'b1}} : v[GCD_BITS-1:0];
  endfunction

  assign sa = sext(in_data.coef_a);
  assign sb = sext(in_data.coef_b);

  // rounding helpers on the divider result
  always_comb begin
    t_pos   = (t_r > 0);
    t_abs   = t_r[MUL_BITS-1] ? -t_r : t_r;
    k_ceil  = div_quo + ((div_rem > 0) ? WIDE_BITS'(1) : WIDE_BITS'(0));
    k_floor = div_quo - ((div_rem < 0) ? WIDE_BITS'(1) : WIDE_BITS'(0));
    rem_pos = (div_rem < 0) ? div_rem + $signed({1'b0, s_r}) : div_rem;
    cnt_w   = kh_r - kl_r + WIDE_BITS'(1);
  end

  // divider operand select
  always_comb begin
    div_num = '0;
    div_den = DEN_BITS'(1);
    case (cmd.op)
      OP_DIV_EUC: begin
        div_num = WIDE_BITS'(r0_r);
        div_den = DEN_BITS'(r1_r);
      end
      OP_DIV_S: begin
        div_num = WIDE_BITS'(r1_r == '0 ? abs32(b_r) : abs32(b_r));
        div_den = DEN_BITS'(g_r);
      end
      OP_DIV_CG: begin
        div_num = WIDE_BITS'(c_r);
        div_den = DEN_BITS'(g_r);
      end
      OP_DIV_U0S: begin
        div_num = WIDE_BITS'(u0_r);
        div_den = DEN_BITS'(s_r);
      end
      OP_DIV_CGS: begin
        div_num = WIDE_BITS'(cg_r);
        div_den = DEN_BITS'(s_r);
      end
      OP_DIV_PS: begin
        div_num = prod_r;
        div_den = DEN_BITS'(s_r);
      end
      OP_DIV_Y: begin
        div_num = WIDE_BITS'(c_r) - prod_r;
        div_den = DEN_BITS'(b_r);
      end
      OP_DIV_T: begin
        div_num = WIDE_BITS'(a_r);
        div_den = DEN_BITS'(g_r);
      end
      OP_DIV_KL: begin
        div_num = WIDE_BITS'(xl_r) - WIDE_BITS'(x0_r);
        div_den = DEN_BITS'(s_r);
      end
      OP_DIV_KH: begin
        div_num = WIDE_BITS'(xh_r) - WIDE_BITS'(x0_r);
        div_den = DEN_BITS'(s_r);
      end
      OP_DIV_LO: begin
        div_num = t_pos ? WIDE_BITS'(yl_r) - WIDE_BITS'(y0_r)
                        : WIDE_BITS'(y0_r) - WIDE_BITS'(yh_r);
        div_den = DEN_BITS'(t_abs);
      end
      OP_DIV_HI: begin
        div_num = t_pos ? WIDE_BITS'(yh_r) - WIDE_BITS'(y0_r)
                        : WIDE_BITS'(y0_r) - WIDE_BITS'(yl_r);
        div_den = DEN_BITS'(t_abs);
      end
      default: begin
        div_num = '0;
        div_den = DEN_BITS'(1);
      end
    endcase
  end

  // multiplier operand select, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_QU: begin
        mul_a = $signed({1'b0, q_r});
        mul_b = u1_r;
      end
      OP_MUL_M: begin
        mul_a = $signed({1'b0, m1_r});
        mul_b = $signed({1'b0, m2_r});
      end
      OP_MUL_AX: begin
        mul_a = MUL_BITS'(a_r);
        mul_b = $signed({1'b0, x0_r});
      end
      OP_MUL_KLS: begin
        mul_a = $signed({1'b0, kl_r[FB-1:0]});
        mul_b = $signed({1'b0, s_r});
      end
      OP_MUL_KLT: begin
        mul_a = $signed({1'b0, kl_r[FB-1:0]});
        mul_b = t_r;
      end
      OP_MUL_KHS: begin
        mul_a = $signed({1'b0, kh_r[FB-1:0]});
        mul_b = $signed({1'b0, s_r});
      end
      OP_MUL_KHT: begin
        mul_a = $signed({1'b0, kh_r[FB-1:0]});
        mul_b = t_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  ldrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // operation execution
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a_r  <= sa;
        b_r  <= sb;
        c_r  <= sext(in_data.rhs_c);
        xl_r <= sext(in_data.x_low);
        xh_r <= sext(in_data.x_high);
        yl_r <= sext(in_data.y_low);
        yh_r <= sext(in_data.y_high);
        r0_r <= abs32(sa);
        r1_r <= abs32(sb);
        u0_r <= MUL_BITS'(1);
        u1_r <= '0;
      end
      OP_SET_EQ: begin
        q_r  <= div_quo[FB-1:0];
        r0_r <= r1_r;
        r1_r <= div_rem[FB-1:0];
      end
      OP_SET_EU: begin
        u0_r <= u1_r;
        u1_r <= u0_r - prod_r[MUL_BITS-1:0];
      end
      OP_SET_G:  g_r  <= r0_r;
      OP_SET_S:  s_r  <= div_quo[FB-1:0];
      OP_SET_CG: cg_r <= div_quo[FB-1:0];
      OP_SET_M1: m1_r <= rem_pos[FB-1:0];
      OP_SET_M2: m2_r <= rem_pos[FB-1:0];
      OP_SET_X0: begin
        // reflect for a negative a, keeping zero at zero
        if (a_r < 0 && div_rem != 0) begin
          x0_r <= s_r - div_rem[FB-1:0];
        end else begin
          x0_r <= div_rem[FB-1:0];
        end
      end
      OP_SET_Y0: y0_r <= div_quo[63:0];
      OP_SET_T:  t_r  <= (b_r > 0) ? -div_quo[MUL_BITS-1:0] : div_quo[MUL_BITS-1:0];
      OP_SET_KL: kl_r <= k_ceil;
      OP_SET_KH: kh_r <= k_floor;
      OP_SET_LO: if (k_ceil > kl_r) kl_r <= k_ceil;
      OP_SET_HI: if (k_floor < kh_r) kh_r <= k_floor;
      OP_SET_FX: fx_r <= x0_r + prod_r[FB-1:0];
      OP_SET_FY: fy_r <= y0_r[FB-1:0] + prod_r[FB-1:0];
      OP_SET_LX: lx_r <= x0_r + prod_r[FB-1:0];
      OP_SET_LY: ly_r <= y0_r[FB-1:0] + prod_r[FB-1:0];
      OP_OUT: begin
        out_r.status    <= cmd.stat;
        out_r.gcd_value <= sat31(g_r);
        out_r.x_step    <= (cmd.stat == ST_ZERO) ? '0 : sat31(s_r);
        if (cmd.stat == ST_OK) begin
          out_r.first_x        <= fx_r;
          out_r.first_y        <= fy_r;
          out_r.last_x         <= lx_r;
          out_r.last_y         <= ly_r;
          out_r.solution_count <= (cnt_w[WIDE_BITS-1:FB] != '0) ? '1 : cnt_w[FB-1:0];
        end else begin
          out_r.first_x        <= '0;
          out_r.first_y        <= '0;
          out_r.last_x         <= '0;
          out_r.last_y         <= '0;
          out_r.solution_count <= '0;
        end
      end
      default: begin
      end
    endcase
    if (cmd.op == OP_MUL_QU || cmd.op == OP_MUL_M || cmd.op == OP_MUL_AX ||
        cmd.op == OP_MUL_KLS || cmd.op == OP_MUL_KLT ||
        cmd.op == OP_MUL_KHS || cmd.op == OP_MUL_KHT) begin
      prod_r <= mul_p;
    end
  end

  // status toward the controller
  always_comb begin
    sts.div_done  = div_done;
    sts.r1_zero   = (r1_r == '0);
    sts.zero_coef = (a_r == '0) || (b_r == '0);
    sts.rem_nz    = (div_rem != '0);
    sts.k_empty   = (kh_r < kl_r);
  end

  assign out_data = out_r;

endmodule

// File: rtl/ldrs_ctrl.sv
// solver controller: handshakes and the operation sequence
module ldrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ldrs_pkg::ldrs_sts_t sts,
  output ldrs_pkg::ldrs_cmd_t cmd
);
  import ldrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_FIN  = 4'b1000
  } ldrs_state_t;

  ldrs_state_t  state_r, state_nxt;
  ldrs_op_t     pc_r, pc_nxt;
  ldrs_status_t stat_r, stat_nxt;
  logic         out_valid_r, out_valid_nxt;

  // next state and command
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NOP;
    cmd.div_start = 1'b0;
    cmd.stat      = stat_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          pc_nxt    = OP_DIV_EUC;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.op = pc_r;
        pc_nxt = ldrs_op_t'(pc_r + 6'd1);
        case (pc_r) inside
          OP_DIV_EUC: begin
            if (sts.r1_zero) begin
              cmd.op = OP_NOP;
              pc_nxt = OP_SET_G;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_WAIT;
            end
          end
          OP_DIV_S, OP_DIV_CG, OP_DIV_U0S, OP_DIV_CGS, OP_DIV_PS, OP_DIV_Y,
          OP_DIV_T, OP_DIV_KL, OP_DIV_KH, OP_DIV_LO, OP_DIV_HI: begin
            cmd.div_start = 1'b1;
            state_nxt     = S_WAIT;
          end
          OP_SET_EU: pc_nxt = OP_DIV_EUC;
          OP_SET_G: begin
            if (sts.zero_coef) begin
              stat_nxt  = ST_ZERO;
              state_nxt = S_FIN;
            end
          end
          OP_SET_CG: begin
            if (sts.rem_nz) begin
              stat_nxt  = ST_NODIV;
              state_nxt = S_FIN;
            end
          end
          OP_CHK: begin
            if (sts.k_empty) begin
              stat_nxt  = ST_NONE;
              state_nxt = S_FIN;
            end
          end
          OP_SET_LY: begin
            stat_nxt  = ST_OK;
            state_nxt = S_FIN;
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        if (sts.div_done) state_nxt = S_RUN;
      end
      S_FIN: begin
        // result register free or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= OP_DIV_EUC;
      stat_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == S_WAIT) else $error("no wait after divide start");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_WAIT) else $error("divide done outside wait");
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |=> out_valid_r) else $error("result not presented");

endmodule

// File: rtl/linear_diophantine_range_solver.sv
// top level of the linear diophantine range solver
//
//  channel | direction | handshake          | payload
//  in_ch   | input     | valid/ready        | coef_a coef_b rhs_c x_low x_high y_low y_high
//  out_ch  | output    | valid/ready        | status gcd_value first/last x,y x_step count
//
// one equation at a time; a transaction is shortest when both coefficients
// are zero.
// the shared divider yields one quotient bit per cycle, so a divide holds the
// sequence for less time when the dividend magnitude fits 32 bits; euclid
// runs up to ~46 steps, then eleven more divides and 23 further steps build
// the solution and the range.
// reset is synchronous, active low, and clears only control state.
// a finished result waits in the output register while the next equation is
// taken; the solver stalls at its end only if that register is still full.
module linear_diophantine_range_solver #(
  parameter int WORD_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  ldrs_in_if.sink    in_ch,
  ldrs_out_if.source out_ch
);
  import ldrs_pkg::*;

  localparam int OP_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;

  ldrs_cmd_t cmd;
  ldrs_sts_t sts;

  ldrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ldrs_dp #(
    .OP_BITS (OP_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_ch.data),
    .out_data (out_ch.data)
  );

endmodule

// File: tb/testbench.sv
// self-checking testbench for the linear diophantine range solver
`timescale 1ns / 1ps

module testbench;
  import ldrs_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 3000;

  logic clk;
  logic rst_n;
  ldrs_in_if  in_ch ();
  ldrs_out_if out_ch ();

  linear_diophantine_range_solver #(.WORD_BITS(32)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // directed stimulus row; expected result typed in where it is obvious
  typedef struct {
    ldrs_in_t  eqn;
    bit        fixed;
    ldrs_out_t want;
  } eqn_row_t;

  ldrs_out_t solution_q[$];
  int        mismatches;
  int        results_seen;
  int        accepted;
  int        status_hist[4];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // fallback end of run
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", solution_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint ceil_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n > 0) q++;
    return q;
  endfunction

  function automatic longint pos_mod(longint n, longint m);
    longint r;
    r = n % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic logic [GCD_BITS-1:0] clip31(longint v);
    return (v > 64'sh7FFF_FFFF) ? {GCD_BITS{1'b1}} : v[GCD_BITS-1:0];
  endfunction

  // solve one equation over its box
  function automatic ldrs_out_t solve_box(ldrs_in_t e);
    ldrs_out_t r;
    longint a, b, c, xl, xh, yl, yh, aa, ab;
    longint r0, r1, u0, u1, q, tmp, g, s, t, x0, y0, kl, kh, lo, hi;
    r  = '0;
    a  = longint'(e.coef_a);
    b  = longint'(e.coef_b);
    c  = longint'(e.rhs_c);
    xl = longint'(e.x_low);
    xh = longint'(e.x_high);
    yl = longint'(e.y_low);
    yh = longint'(e.y_high);
    aa = (a < 0) ? -a : a;
    ab = (b < 0) ? -b : b;
    r0 = aa; r1 = ab; u0 = 1; u1 = 0;
    // extended euclid, only the |a| coefficient is tracked
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = u0 - q * u1; u0 = u1; u1 = tmp;
    end
    g = r0;
    r.gcd_value = clip31(g);
    if (a == 0 || b == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    s = ab / g;
    r.x_step = clip31(s);
    if (c % g != 0) begin
      r.status = ST_NODIV;
      return r;
    end
    // particular solution with x reduced modulo the step
    x0 = pos_mod(pos_mod(u0, s) * pos_mod(c / g, s), s);
    if (a < 0) x0 = pos_mod(s - x0, s);
    y0 = (c - a * x0) / b;
    t = (b > 0) ? -(a / g) : (a / g);
    kl = ceil_div(xl - x0, s);
    kh = floor_div(xh - x0, s);
    if (t > 0) begin
      lo = ceil_div(yl - y0, t);
      hi = floor_div(yh - y0, t);
    end else begin
      lo = ceil_div(y0 - yh, -t);
      hi = floor_div(y0 - yl, -t);
    end
    if (lo > kl) kl = lo;
    if (hi < kh) kh = hi;
    if (kh < kl) begin
      r.status = ST_NONE;
      return r;
    end
    r.status  = ST_OK;
    tmp = x0 + kl * s; r.first_x = tmp[31:0];
    tmp = y0 + kl * t; r.first_y = tmp[31:0];
    tmp = x0 + kh * s; r.last_x  = tmp[31:0];
    tmp = y0 + kh * t; r.last_y  = tmp[31:0];
    tmp = kh - kl + 1;
    r.solution_count = (tmp > 64'sh FFFF_FFFF) ? 32'hFFFF_FFFF : tmp[31:0];
    return r;
  endfunction

  function automatic ldrs_in_t mk_eqn(int a, int b, int c, int xl, int xh, int yl, int yh);
    ldrs_in_t e;
    e.coef_a = a; e.coef_b = b; e.rhs_c = c;
    e.x_low = xl; e.x_high = xh; e.y_low = yl; e.y_high = yh;
    return e;
  endfunction

  function automatic ldrs_out_t mk_res(ldrs_status_t st, int g, int stp, int fx, int fy,
                                      int lx, int ly, int cnt);
    ldrs_out_t r;
    r.status = st; r.gcd_value = GCD_BITS'(g); r.x_step = GCD_BITS'(stp);
    r.first_x = fx; r.first_y = fy; r.last_x = lx; r.last_y = ly;
    r.solution_count = cnt;
    return r;
  endfunction

  // random signed word of mixed magnitude
  function automatic int rnd_word();
    case ($urandom_range(0, 3))
      0: return int'($urandom());
      1: return int'($urandom_range(0, 200)) - 100;
      2: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0001)
                - int'($urandom_range(0, 3));
      default: return int'($urandom_range(0, 2_000_000)) - 1_000_000;
    endcase
  endfunction

  // equation built around a known solution, box placed near it
  function automatic ldrs_in_t solvable_eqn();
    int a, b, x, y, span_x, span_y, lim;
    lim = $urandom_range(0, 3) == 0 ? 1_000_000 : 60;
    a = int'($urandom_range(1, lim));
    b = int'($urandom_range(1, lim));
    if ($urandom_range(0, 1)) a = -a;
    if ($urandom_range(0, 1)) b = -b;
    x = int'($urandom_range(0, 1000)) - 500;
    y = int'($urandom_range(0, 1000)) - 500;
    span_x = $urandom_range(0, 3) == 0 ? 100_000 : int'($urandom_range(0, 300));
    span_y = $urandom_range(0, 3) == 0 ? 100_000 : int'($urandom_range(0, 300));
    return mk_eqn(a, b, a * x + b * y,
                  x - int'($urandom_range(0, span_x)), x + int'($urandom_range(0, span_x)),
                  y - int'($urandom_range(0, span_y)), y + int'($urandom_range(0, span_y)));
  endfunction

  function automatic ldrs_in_t noise_eqn();
    return mk_eqn(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                  rnd_word(), rnd_word());
  endfunction

  // send one transaction, holding valid until it is taken
  task automatic send_eqn(ldrs_in_t e);
    in_ch.data  = e;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // record expected result per accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      solution_q.push_back(solve_box(in_ch.data));
      accepted++;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    ldrs_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      status_hist[out_ch.data.status]++;
      if (solution_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
      end else begin
        want = solution_q.pop_front();
        if (out_ch.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d\n  exp %p\n  got %p",
                     results_seen, want, out_ch.data);
        end
      end
    end
  end

  // receiver stalls on a rotating random pattern, sometimes never
  initial begin
    logic [15:0] pattern;
    out_ch.ready = 1'b0;
    pattern = 16'hFFFF;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0)
        pattern = $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom());
      out_ch.ready = pattern[0];
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  // stimulus
  initial begin
    eqn_row_t rows[$];
    eqn_row_t row;
    int burst;
    int n;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    mismatches = 0; results_seen = 0; accepted = 0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // zero coefficients
    rows.push_back('{mk_eqn(0, 0, 5, 0, 9, 0, 9), 1, mk_res(ST_ZERO, 0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_eqn(0, 5, 5, 0, 9, 0, 9), 1, mk_res(ST_ZERO, 5, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_eqn(-7, 0, 5, 0, 9, 0, 9), 1, mk_res(ST_ZERO, 7, 0, 0, 0, 0, 0, 0)});
    // gcd does not divide c
    rows.push_back('{mk_eqn(4, 6, 3, 0, 9, 0, 9), 1, mk_res(ST_NODIV, 2, 3, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_eqn(-4, -6, 1, 0, 9, 0, 9), 1, mk_res(ST_NODIV, 2, 3, 0, 0, 0, 0, 0)});
    // empty boxes
    rows.push_back('{mk_eqn(1, 1, 0, 5, 4, -9, 9), 1, mk_res(ST_NONE, 1, 1, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_eqn(1, 1, 0, -9, 9, 3, 2), 1, mk_res(ST_NONE, 1, 1, 0, 0, 0, 0, 0)});
    // single point solution
    rows.push_back('{mk_eqn(1, 1, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 1, 1, 0, 0, 0, 0, 1)});
    // sign combinations and boxes that miss
    rows.push_back('{mk_eqn(3, 5, 7, -20, 20, -20, 20), 0, '0});
    rows.push_back('{mk_eqn(-3, 5, 7, -20, 20, -20, 20), 0, '0});
    rows.push_back('{mk_eqn(3, -5, -7, -20, 20, -20, 20), 0, '0});
    rows.push_back('{mk_eqn(-3, -5, 7, -20, 20, -20, 20), 0, '0});
    rows.push_back('{mk_eqn(6, 10, 1000, 1000, 2000, -50, 50), 0, '0});
    // extremes of the fields
    rows.push_back('{mk_eqn(32'sh8000_0000, 32'sh8000_0000, 0, -9, 9, -9, 9), 0, '0});
    rows.push_back('{mk_eqn(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh7FFF_FFFF), 0, '0});
    rows.push_back('{mk_eqn(1, -1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh7FFF_FFFF), 0, '0});
    rows.push_back('{mk_eqn(32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF,
                            32'sh8000_0001, 32'sh7FFF_FFFF, 32'sh8000_0001,
                            32'sh7FFF_FFFF), 0, '0});
    rows.push_back('{mk_eqn(32'sh8000_0001, 1, 32'sh8000_0001, 0, 5,
                            32'sh8000_0001, 32'sh7FFF_FFFF), 0, '0});
    // long euclid chain from consecutive fibonacci numbers
    rows.push_back('{mk_eqn(1836311903, 1134903170, 1, 32'sh8000_0001, 32'sh7FFF_FFFF,
                            32'sh8000_0001, 32'sh7FFF_FFFF), 0, '0});
    rows.push_back('{mk_eqn(-1134903170, 701408733, -1, 32'sh8000_0001, 32'sh7FFF_FFFF,
                            32'sh8000_0001, 32'sh7FFF_FFFF), 0, '0});

    foreach (rows[i]) begin
      row = rows[i];
      if (row.fixed && solve_box(row.eqn) !== row.want) begin
        mismatches++;
        $display("directed row %0d disagrees with the predictor", i);
      end
      send_eqn(row.eqn);
    end

    // hold off until the block has drained
    in_ch.valid = 1'b0;
    wait (solution_q.size() == 0);
    @(negedge clk);

    // random part in bursts with gaps
    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_eqn($urandom_range(0, 3) == 0 ? noise_eqn() : solvable_eqn());
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
    end
    in_ch.valid = 1'b0;

    wait (solution_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d equations solved: %0d with solutions, %0d not divisible, %0d outside box,",
             results_seen, status_hist[ST_OK], status_hist[ST_NODIV], status_hist[ST_NONE]);
    $display("%0d with a zero coefficient; %0d mismatches", status_hist[ST_ZERO], mismatches);
    if (mismatches == 0 && solution_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ldrs_pkg.sv
rtl/ldrs_if.sv
rtl/ldrs_div.sv
rtl/ldrs_dp.sv
rtl/ldrs_ctrl.sv
rtl/linear_diophantine_range_solver.sv
tb/testbench.sv
